>>> hdl/pip_pkg.sv
package pip_pkg;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  // Status codes of a result transaction
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_FEW  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
  } pip_in_t;

  typedef struct packed {
    logic       inside_res;
    logic [1:0] status;
  } pip_out_t;

endpackage

>>> hdl/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/point_in_polygon_test.sv
// Even-odd point-in-polygon test over one stored polygon.
// Input channel in_valid/in_ready/in_data carries one transaction per item:
// append a vertex, clear the polygon, or query a point. Result channel
// out_valid/out_ready/out_data returns exactly one transaction per item with
// the inside flag and a status code (ok, store full, too few vertices).
// Vertices live in one on-chip RAM of MAX_VERTICES entries; the bounding box
// and vertex count sit in registers.
// Append, clear, and queries that end early (fewer than three vertices or
// outside the box) finish without a RAM scan: the result is visible the
// cycle after acceptance when the output is free, and a new item can follow
// every cycle while out_ready is high. A full query reads the RAM once per
// vertex plus once for the closing vertex, feeding an edge pipeline
// (differences, magnitudes, COORD_WIDTH x COORD_WIDTH products, and a
// combinational compare). No new item is taken while a query runs.
// Reset empties the polygon and the box; RAM contents are left as they are.
// A stalled receiver holds the result in the output register; one more item
// may be taken and finished, then the block waits for the output to drain.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pip_pkg::pip_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pip_pkg::pip_out_t  out_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * CW;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_VERTICES);
  localparam logic [CNTW-1:0] MIN_CNT = CNTW'(3);

  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_HOLD  = 2'd3;

  // Control and polygon state
  logic [1:0]              state_r, state_nxt;
  logic [CNTW-1:0]         cnt_r, cnt_nxt;
  logic [CNTW-1:0]         iss_r, iss_nxt;
  logic signed [CW-1:0]    min_x_r, min_x_nxt, max_x_r, max_x_nxt;
  logic signed [CW-1:0]    min_y_r, min_y_nxt, max_y_r, max_y_nxt;
  logic                    par_r, par_nxt;
  pip_pkg::pip_out_t       res_r, res_nxt;
  logic signed [CW-1:0]    qx_r, qy_r;
  logic                    out_valid_r;
  pip_pkg::pip_out_t       out_data_r;

  // RAM ports
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [CNTW-1:0]         raddr_full;
  logic [PW-1:0]           ram_rdata;
  logic                    first_rd;

  // Handshake and decoded input
  logic                    accept, out_free, ld_out, pipe_busy;
  pip_pkg::pip_out_t       ld_data;
  logic signed [CW-1:0]    in_x, in_y;

  // Edge pipeline
  logic                    rd_vld_r, rd_first_r;
  logic signed [CW-1:0]    prev_x_r, prev_y_r, cur_x, cur_y;
  logic signed [DW-1:0]    qx_e, qy_e, cx_e, cy_e, px_e, py_e;
  logic                    a_vld_r, a_cross_r;
  logic signed [DW-1:0]    a_dpx_r, a_dy_r, a_dpy_r, a_dx_r;
  logic                    b_vld_r, b_cross_r, b_lneg_r, b_rneg_r;
  logic [CW-1:0]           b_la_r, b_lb_r, b_ra_r, b_rb_r;
  logic                    c_vld_r, c_cross_r, c_lneg_r, c_rneg_r;
  logic [PW-1:0]           c_lp_r, c_rp_r;
  logic                    d_less, d_hit;

  function automatic logic [CW-1:0] mag_f(input logic signed [DW-1:0] v);
    logic [DW-1:0] n;
    n = v[DW-1] ? (~v + 1'b1) : v;
    return n[CW-1:0];
  endfunction

  assign in_x     = in_data.x_coord[CW-1:0];
  assign in_y     = in_data.y_coord[CW-1:0];
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign pipe_busy = rd_vld_r || a_vld_r || b_vld_r || c_vld_r;

  // Sequence items, update the polygon, pick the result
  always_comb begin
    pip_pkg::pip_out_t res_v;
    logic              has_res;
    res_v      = '0;
    has_res    = 1'b0;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    iss_nxt    = iss_r;
    min_x_nxt  = min_x_r;
    max_x_nxt  = max_x_r;
    min_y_nxt  = min_y_r;
    max_y_nxt  = max_y_r;
    par_nxt    = d_hit ? !par_r : par_r;
    res_nxt    = res_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    first_rd   = 1'b0;
    raddr_full = '0;
    ld_out     = 1'b0;
    ld_data    = res_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          has_res      = 1'b1;
          res_v.status = pip_pkg::STAT_OK;
          case (in_data.opcode)
            pip_pkg::OP_APPEND: begin
              if (cnt_r >= MAX_CNT) begin
                res_v.status = pip_pkg::STAT_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                if (in_x < min_x_r) min_x_nxt = in_x;
                if (in_x > max_x_r) max_x_nxt = in_x;
                if (in_y < min_y_r) min_y_nxt = in_y;
                if (in_y > max_y_r) max_y_nxt = in_y;
              end
            end
            pip_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              min_x_nxt = C_MAX;
              min_y_nxt = C_MAX;
              max_x_nxt = C_MIN;
              max_y_nxt = C_MIN;
            end
            pip_pkg::OP_QUERY: begin
              if (cnt_r < MIN_CNT) begin
                res_v.status = pip_pkg::STAT_FEW;
              end else if (in_x >= min_x_r && in_x <= max_x_r &&
                           in_y >= min_y_r && in_y <= max_y_r) begin
                has_res   = 1'b0;
                state_nxt = S_SCAN;
                iss_nxt   = '0;
                par_nxt   = 1'b0;
              end
            end
            default: begin
              res_v.status = pip_pkg::STAT_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Read the closing vertex first, then vertices in order
        ram_re   = 1'b1;
        first_rd = (iss_r == '0);
        raddr_full = first_rd ? (cnt_r - 1'b1) : (iss_r - 1'b1);
        iss_nxt  = iss_r + 1'b1;
        if (iss_r == cnt_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          has_res          = 1'b1;
          res_v.inside_res = par_r;
          res_v.status     = pip_pkg::STAT_OK;
          state_nxt        = S_IDLE;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          ld_out    = 1'b1;
          ld_data   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // Send the result now or park it until the output drains
    if (has_res) begin
      if (out_free) begin
        ld_out  = 1'b1;
        ld_data = res_v;
      end else begin
        res_nxt   = res_v;
        state_nxt = S_HOLD;
      end
    end
  end

  assign ram_raddr = raddr_full[AW-1:0];

  pip_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({in_x, in_y}),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign cur_x = ram_rdata[PW-1:CW];
  assign cur_y = ram_rdata[CW-1:0];
  assign qx_e  = {qx_r[CW-1], qx_r};
  assign qy_e  = {qy_r[CW-1], qy_r};
  assign cx_e  = {cur_x[CW-1], cur_x};
  assign cy_e  = {cur_y[CW-1], cur_y};
  assign px_e  = {prev_x_r[CW-1], prev_x_r};
  assign py_e  = {prev_y_r[CW-1], prev_y_r};

  // Compare signed products: left side strictly below right side
  always_comb begin
    d_less = (c_lneg_r && !c_rneg_r) ||
             (!c_lneg_r && !c_rneg_r && (c_lp_r < c_rp_r)) ||
             (c_lneg_r && c_rneg_r && (c_lp_r > c_rp_r));
    d_hit  = c_vld_r && c_cross_r && d_less;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      iss_r       <= '0;
      min_x_r     <= C_MAX;
      min_y_r     <= C_MAX;
      max_x_r     <= C_MIN;
      max_y_r     <= C_MIN;
      par_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      iss_r    <= iss_nxt;
      min_x_r  <= min_x_nxt;
      min_y_r  <= min_y_nxt;
      max_x_r  <= max_x_nxt;
      max_y_r  <= max_y_nxt;
      par_r    <= par_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= ram_re;
      a_vld_r  <= rd_vld_r && !rd_first_r;
      b_vld_r  <= a_vld_r;
      c_vld_r  <= b_vld_r;
    end
  end

  // Payload registers and edge pipeline data
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (ld_out) begin
      out_data_r <= ld_data;
    end
    if (accept) begin
      qx_r <= in_x;
      qy_r <= in_y;
    end
    rd_first_r <= first_rd;
    // Stage A: hold previous vertex, form differences for edge j-i
    if (rd_vld_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    a_cross_r <= (cur_y > qy_r) != (prev_y_r > qy_r);
    a_dpx_r   <= qx_e - cx_e;
    a_dy_r    <= py_e - cy_e;
    a_dpy_r   <= qy_e - cy_e;
    a_dx_r    <= px_e - cx_e;
    // Stage B: magnitudes and product signs
    b_cross_r <= a_cross_r;
    b_la_r    <= mag_f(a_dpx_r);
    b_lb_r    <= mag_f(a_dy_r);
    b_ra_r    <= mag_f(a_dpy_r);
    b_rb_r    <= mag_f(a_dx_r);
    b_lneg_r  <= a_dpx_r[DW-1] && (a_dpx_r != '0) && (a_dy_r != '0);
    b_rneg_r  <= (a_dpy_r[DW-1] ^ a_dx_r[DW-1] ^ a_dy_r[DW-1]) &&
                 (a_dpy_r != '0) && (a_dx_r != '0);
    // Stage C: products
    c_cross_r <= b_cross_r;
    c_lneg_r  <= b_lneg_r;
    c_rneg_r  <= b_rneg_r;
    c_lp_r    <= PW'(b_la_r) * PW'(b_lb_r);
    c_rp_r    <= PW'(b_ra_r) * PW'(b_rb_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
